[hdl/assert_macros.svh]
// assertion macros shared by the console writer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define TCW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// condition must never be seen at a clock edge outside reset
`define TCW_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

[hdl/tcw_pkg.sv]
// shared types and constants of the text console writer
`default_nettype none

package tcw_pkg;

  // stream payload widths
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;
  localparam int IDX_W       = 11;
  localparam int CELL_W      = 16;

  // control characters
  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_BS  = 8'd8;

  localparam int TAB_STEP = 4;

  // configuration register indexes
  localparam logic CFG_FG = 1'b0;
  localparam logic CFG_BG = 1'b1;

  // command queue geometry
  localparam int QDEPTH = 2;
  localparam int QPW    = 1;

  // decoded operation of one item
  typedef enum logic [2:0] {
    OP_READ,
    OP_NEWLINE,
    OP_TAB,
    OP_BKSP,
    OP_PRINT
  } op_e;

  // one queued command
  typedef struct packed {
    op_e              op;
    logic [7:0]       ch;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  // status from the execution side
  typedef struct packed {
    logic init_done;
    logic pop;
  } back_stat_t;

endpackage

`default_nettype wire

[hdl/tcw_front.sv]
// input side: accepts stream items and decodes them into commands
`default_nettype none

module tcw_front import tcw_pkg::*; (
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,  // char_code, cell_index
  input  wire logic                  s_axis_tuser,  // req_type
  input  wire logic                  q_ready_i,
  input  wire logic                  init_done_i,
  output logic                       push_o,
  output cmd_t                       cmd_o
);

  logic [7:0] ch;

  assign ch = s_axis_tdata[7:0];

  // take items only once the screen clear has finished and the queue has room
  assign s_axis_tready = q_ready_i && init_done_i;
  assign push_o        = s_axis_tvalid && s_axis_tready;

  // classify the item
  always_comb begin
    cmd_o.ch  = ch;
    cmd_o.idx = s_axis_tdata[IDX_W+7:8];
    if (s_axis_tuser) begin
      cmd_o.op = OP_READ;
    end else begin
      unique case (ch) inside
        CH_CR, CH_LF: cmd_o.op = OP_NEWLINE;
        CH_TAB:       cmd_o.op = OP_TAB;
        CH_BS:        cmd_o.op = OP_BKSP;
        default:      cmd_o.op = OP_PRINT;
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/tcw_fifo.sv]
// short command queue between decode and execution
`default_nettype none

module tcw_fifo import tcw_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  output logic      ready_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output cmd_t      cmd_o
);

  cmd_t           entry_q [QDEPTH];
  logic [QPW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPW:0]   count_q, count_d;

  assign ready_o = count_q != (QPW+1)'(QDEPTH);
  assign valid_o = count_q != '0;
  assign cmd_o   = entry_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + QPW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + QPW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + (QPW+1)'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - (QPW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

[hdl/tcw_back.sv]
// execution side: cursor, screen memory, scroll and result register
`default_nettype none

module tcw_back import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   q_valid_i,
  input  wire cmd_t                   q_cmd_i,
  input  wire logic [3:0]             fg_i,
  input  wire logic [3:0]             bg_i,
  output back_stat_t                  stat_o,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata  // cursor_index, cell_data
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int MOVE  = CELLS - COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int EW    = AW + IDX_W;

  // sequencer states
  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_BKWR   = 3'd2;
  localparam logic [2:0] ST_SCROLL = 3'd3;
  localparam logic [2:0] ST_SCLR   = 3'd4;
  localparam logic [2:0] ST_RESP   = 3'd5;

  logic [2:0]             state_q, state_d;
  logic [RW-1:0]          row_q, row_d;
  logic [CW-1:0]          col_q, col_d;
  logic [AW-1:0]          scr_q, scr_d;
  logic                   resp_read_q, resp_read_d;
  logic                   rd_zero_q, rd_zero_d;
  logic                   out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;

  logic [CELL_W-1:0]      screen_q [CELLS];
  logic [CELL_W-1:0]      rdata_q;

  logic                   we, re, pop, adv;
  logic [AW-1:0]          waddr, raddr;
  logic [CELL_W-1:0]      wdata;

  logic [7:0]             attr;
  logic [AW-1:0]          cur_addr;
  logic [EW-1:0]          cur_ext, idx_ext;
  logic                   in_range;
  logic                   out_free;
  logic                   row_last;
  logic [CW:0]            col_sum;
  logic                   col_wrap;
  logic [CW:0]            col_wrapped;
  logic [CELL_W-1:0]      resp_data;

  assign attr     = {bg_i, fg_i};
  assign cur_addr = AW'(row_q) * AW'(COLUMNS) + AW'(col_q);
  assign cur_ext  = EW'(cur_addr);
  assign idx_ext  = EW'(q_cmd_i.idx);
  assign in_range = idx_ext < EW'(CELLS);
  assign out_free = !out_valid_q || m_axis_tready;
  assign row_last = row_q == RW'(ROWS - 1);

  // column advance for tab or printed character, wraps at most once
  assign col_sum     = (CW+1)'(col_q) +
                       ((q_cmd_i.op == OP_TAB) ? (CW+1)'(TAB_STEP) : (CW+1)'(1));
  assign col_wrap    = col_sum >= (CW+1)'(COLUMNS);
  assign col_wrapped = col_sum - (CW+1)'(COLUMNS);

  assign resp_data = (resp_read_q && !rd_zero_q) ? rdata_q : '0;

  // sequencer
  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    col_d       = col_q;
    scr_d       = scr_q;
    resp_read_d = resp_read_q;
    rd_zero_d   = rd_zero_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    we          = 1'b0;
    re          = 1'b0;
    waddr       = cur_addr;
    raddr       = idx_ext[AW-1:0];
    wdata       = '0;
    pop         = 1'b0;
    adv         = 1'b0;

    unique case (state_q)
      // zero the screen after reset, one cell a cycle
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = scr_q;
        if (scr_q == AW'(CELLS - 1)) begin
          scr_d   = '0;
          state_d = ST_IDLE;
        end else begin
          scr_d = scr_q + AW'(1);
        end
      end

      // take one command and act on it
      ST_IDLE: begin
        if (q_valid_i && out_free) begin
          pop         = 1'b1;
          resp_read_d = 1'b0;
          rd_zero_d   = 1'b0;
          state_d     = ST_RESP;
          case (q_cmd_i.op)
            OP_READ: begin
              resp_read_d = 1'b1;
              rd_zero_d   = !in_range;
              re          = in_range;
            end
            OP_NEWLINE: begin
              col_d = '0;
              adv   = 1'b1;
            end
            OP_TAB, OP_PRINT: begin
              if (q_cmd_i.op == OP_PRINT) begin
                we    = 1'b1;
                wdata = {attr, q_cmd_i.ch};
              end
              if (col_wrap) begin
                col_d = col_wrapped[CW-1:0];
                adv   = 1'b1;
              end else begin
                col_d = col_sum[CW-1:0];
              end
            end
            OP_BKSP: begin
              if (col_q != '0) begin
                col_d = col_q - CW'(1);
              end else if (row_q != '0) begin
                row_d = row_q - RW'(1);
                col_d = CW'(COLUMNS - 1);
              end
              state_d = ST_BKWR;
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
          // next row, or scroll when already on the bottom row
          if (adv) begin
            if (row_last) begin
              state_d = ST_SCROLL;
            end else begin
              row_d = row_q + RW'(1);
            end
          end
        end
      end

      // blank the cell under the moved cursor
      ST_BKWR: begin
        we      = 1'b1;
        wdata   = {attr, 8'h00};
        state_d = ST_RESP;
      end

      // copy each cell one row up: read ahead, write in the following cycle
      ST_SCROLL: begin
        if (scr_q != '0) begin
          we    = 1'b1;
          waddr = scr_q - AW'(1);
          wdata = rdata_q;
        end
        if (scr_q == AW'(MOVE)) begin
          state_d = ST_SCLR;
        end else begin
          re    = 1'b1;
          raddr = scr_q + AW'(COLUMNS);
          scr_d = scr_q + AW'(1);
        end
      end

      // zero the bottom row
      ST_SCLR: begin
        we    = 1'b1;
        waddr = scr_q;
        if (scr_q == AW'(CELLS - 1)) begin
          scr_d   = '0;
          state_d = ST_RESP;
        end else begin
          scr_d = scr_q + AW'(1);
        end
      end

      // load the result register
      ST_RESP: begin
        out_valid_d = 1'b1;
        out_data_d  = OUT_TDATA_W'({resp_data, cur_ext[IDX_W-1:0]});
        state_d     = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      row_q       <= '0;
      col_q       <= '0;
      scr_q       <= '0;
      resp_read_q <= 1'b0;
      rd_zero_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      scr_q       <= scr_d;
      resp_read_q <= resp_read_d;
      rd_zero_q   <= rd_zero_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  // screen memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      screen_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= screen_q[raddr];
    end
  end

  assign stat_o.init_done = state_q != ST_CLEAR;
  assign stat_o.pop       = pop;
  assign m_axis_tvalid    = out_valid_q;
  assign m_axis_tdata     = out_data_q;

endmodule

`default_nettype wire

[hdl/text_console_writer.sv]
// Text console writer: a command leaves the queue head once the result register is
// free, passes ST_BKWR (backspace) or ST_SCROLL and ST_SCLR (scroll) and loads the
// result register in ST_RESP before the next command is taken; the screen memory has
// one write port. After reset the screen memory is zeroed one cell at a time, during
// which no stream item is taken; configuration writes are always taken.
// Reset sets fg_color to 15, bg_color to 0 and the cursor to row 0 column 0.
`default_nettype none
`include "assert_macros.svh"

module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // char_code[7:0], cell_index[18:8]
  input  wire logic                   s_axis_tuser,   // req_type
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // cursor_index[10:0], cell_data[26:11]
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic                   cfg_index_i,
  input  wire logic [3:0]             cfg_data_i
);

  logic [3:0] fg_q, fg_d;
  logic [3:0] bg_q, bg_d;

  logic       push;
  cmd_t       front_cmd;
  logic       q_ready;
  logic       q_valid;
  cmd_t       q_cmd;
  back_stat_t back_stat;

  // color registers
  assign cfg_ready_o = 1'b1;

  always_comb begin
    fg_d = fg_q;
    bg_d = bg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FG:  fg_d = cfg_data_i;
        CFG_BG:  bg_d = cfg_data_i;
        default: fg_d = fg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= 4'hF;
      bg_q <= 4'h0;
    end else begin
      fg_q <= fg_d;
      bg_q <= bg_d;
    end
  end

  // decode
  tcw_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_ready_i     (q_ready),
    .init_done_i   (back_stat.init_done),
    .push_o        (push),
    .cmd_o         (front_cmd)
  );

  // command queue
  tcw_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .ready_o (q_ready),
    .pop_i   (back_stat.pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  // execution
  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_cmd_i       (q_cmd),
    .fg_i          (fg_q),
    .bg_i          (bg_q),
    .stat_o        (back_stat),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // checks
  `TCW_ASSERT(a_no_transfer_in_clear, (s_axis_tvalid && s_axis_tready) |-> back_stat.init_done, "input transfer during screen clear")
  `TCW_ASSERT(a_init_stays_done, back_stat.init_done |=> back_stat.init_done, "screen clear restarted")
  `TCW_ASSERT_NEVER(a_pop_empty_queue, back_stat.pop && !q_valid, "command taken from empty queue")

endmodule

`default_nettype wire
